// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 3;
    localparam int NIB_W   = 4;

    // deframer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PACKET = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESCAPE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUM_HI = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SUM_LO = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BREAK   = 2'd3;

    // framing characters
    localparam logic [BYTE_W-1:0] BYTE_START = 8'h24;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h23;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h7d;
    localparam logic [BYTE_W-1:0] BYTE_BREAK = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_ACK   = 8'h2b;
    localparam logic [BYTE_W-1:0] BYTE_NAK   = 8'h2d;
    localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  running_sum;
        logic [NIB_W-1:0]   high_nibble;
    } dpd_state_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } dpd_result_t;

    // non-hex characters decode as zero
    function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        begin
            d = '0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end
            return d[NIB_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/dpd_step.sv =====
module dpd_step
    import dpd_pkg::*;
(
    input  dpd_state_t        state_cur,
    input  logic [BYTE_W-1:0] rx_byte,
    output dpd_state_t        state_next,
    output dpd_result_t       result
);

    logic [BYTE_W-1:0] sum_plus;
    logic [BYTE_W-1:0] expect_sum;

    assign sum_plus   = state_cur.running_sum + rx_byte;
    assign expect_sum = {state_cur.high_nibble, hex_value(rx_byte)};

    always_comb begin
        state_next   = state_cur;
        result.valid = 1'b0;
        result.kind  = KIND_PAYLOAD;
        result.data  = rx_byte;
        unique case (state_cur.phase)
            PH_PACKET: begin
                if (rx_byte == BYTE_END) begin
                    state_next.phase = PH_SUM_HI;
                end else begin
                    state_next.running_sum = sum_plus;
                    if (rx_byte == BYTE_ESC) begin
                        state_next.phase = PH_ESCAPE;
                    end else begin
                        result.valid = 1'b1;
                    end
                end
            end
            PH_ESCAPE: begin
                state_next.running_sum = sum_plus;
                state_next.phase       = PH_PACKET;
                result.valid           = 1'b1;
                result.data            = rx_byte ^ ESC_XOR;
            end
            PH_SUM_HI: begin
                state_next.high_nibble = hex_value(rx_byte);
                state_next.phase       = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                state_next.phase = PH_IDLE;
                result.valid     = 1'b1;
                if (expect_sum == state_cur.running_sum) begin
                    result.kind = KIND_GOOD;
                    result.data = BYTE_ACK;
                end else begin
                    result.kind = KIND_BAD;
                    result.data = BYTE_NAK;
                end
            end
            default: begin
                // idle, and unused codes fall back to idle
                state_next.phase = PH_IDLE;
                if (rx_byte == BYTE_START) begin
                    state_next.running_sum = '0;
                    state_next.phase       = PH_PACKET;
                end else if (rx_byte == BYTE_BREAK) begin
                    result.valid = 1'b1;
                    result.kind  = KIND_BREAK;
                    result.data  = BYTE_BREAK;
                end
            end
        endcase
    end

endmodule

// ===== rtl/debug_packet_deframer_core.sv =====
// debug packet deframer: splits a received byte stream of $payload#hh packets
// input channel s_*: one raw received byte per word in s_tdata
// result channel m_*: m_tuser holds the kind (payload, packet good,
//   packet bad, break seen), m_tdata the unescaped payload byte or the
//   ack character '+' / '-' (0x03 for a break)
// bytes outside a packet other than '$' and the break byte give no word
// path: a byte lands in the input register, and its result is then loaded into
//   the result register, which drives m_tvalid
// throughput: one byte per cycle while the receiver takes results, set by the
//   state update between the input register and the result register
// when the receiver stalls, the result register holds its word and the
//   input register still takes one more byte; after that s_tready drops
//   until the result word is taken; bytes that give no result still wait
//   behind a held result word
// reset (aresetn low, synchronous): both registers empty, phase idle,
//   running sum and checksum nibble cleared
module debug_packet_deframer_core
    import dpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [KIND_W-1:0] m_tuser    // [1:0] out_kind
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    dpd_state_t        state_reg;
    dpd_state_t        state_next;
    dpd_result_t       result;
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              advance;

    dpd_step u_step (
        .state_cur  (state_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (result)
    );

    // the held word moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: PH_IDLE, running_sum: '0, high_nibble: '0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_kind_reg <= result.kind;
            out_byte_reg <= result.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

endmodule
